// ===== rtl/core/stb_pkg.sv =====
// Package for the software timer bank.
// Holds function and result codes, payload structs and the push interface type.
// No dependencies.
`default_nettype none

package stb_pkg;

   localparam int SLOT_W      = 4;
   localparam int TIMEOUT_W   = 32;
   localparam int MAX_RESULTS = 16;

   localparam logic [2:0] FUNC_TICK      = 3'd0;
   localparam logic [2:0] FUNC_ADD       = 3'd1;
   localparam logic [2:0] FUNC_REMOVE    = 3'd2;
   localparam logic [2:0] FUNC_EXECUTE   = 3'd3;
   localparam logic [2:0] FUNC_CHECK     = 3'd4;
   localparam logic [2:0] FUNC_SET_DELAY = 3'd5;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_FIRED = 2'd1;
   localparam logic [1:0] KIND_CHECK = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   typedef struct packed {
      logic [2:0]           func;
      logic [SLOT_W-1:0]    slot;
      logic                 timer_type;
      logic [TIMEOUT_W-1:0] timeout;
      logic                 has_handler;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [SLOT_W-1:0] fired_slot;
      logic              expired;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic    en;
      rsp_type data;
   } push_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/stb_rsp_stage.sv =====
// Response output register for the software timer bank.
// Depends on stb_pkg (rsp_type, push_type).
`default_nettype none

module stb_rsp_stage import stb_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          can_push,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   assign can_push = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push.en) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/stb_ctrl.sv =====
// Sequencer and timer slot memory for the software timer bank.
// Depends on stb_pkg (codes, req_type, rsp_type, push_type, mem_ctl_type).
`default_nettype none

module stb_ctrl import stb_pkg::*; #(
   parameter int NUM_TIMERS = 16,
   parameter int COUNT_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    can_push,
   output push_type     push
);

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = IW + 1;
   localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;
   localparam int EW = 2 + 2 * COUNT_BITS;
   localparam int NW = $clog2(MAX_RESULTS + 1);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_WALK     = 3'd2;
   localparam logic [2:0] ST_CHECK    = 3'd3;
   localparam logic [2:0] ST_FINAL    = 3'd4;

   logic [EW-1:0]         timer_mem_ff [NUM_TIMERS];
   logic [EW-1:0]         rd_data_ff;

   logic [2:0]            state_ff, state_in;
   req_type               req_ff, req_in;
   logic [NUM_TIMERS-1:0] active_ff, active_in;
   logic [COUNT_BITS-1:0] delay_ff, delay_in;
   logic [CW-1:0]         rd_idx_ff, rd_idx_in;
   logic                  p_ff, p_in;
   logic [IW-1:0]         p_idx_ff, p_idx_in;
   logic                  hold_valid_ff, hold_valid_in;
   logic [SLOT_W-1:0]     hold_slot_ff, hold_slot_in;
   logic [NW-1:0]         n_ff, n_in;
   rsp_type               fin_ff, fin_in;

   mem_ctl_type           mem_ctl;
   logic [IW-1:0]         wr_addr;
   logic [IW-1:0]         rd_addr;
   logic [EW-1:0]         wr_data;

   logic [SW-1:0]         slot_wide;
   logic [IW-1:0]         slot_idx;
   logic                  in_bank;
   logic                  slot_zero;
   logic [COUNT_BITS-1:0] tmo;

   logic                  e_cyc;
   logic                  e_hnd;
   logic [COUNT_BITS-1:0] e_reload;
   logic [COUNT_BITS-1:0] e_count;
   logic                  act;
   logic                  is_exec;
   logic                  fire;
   logic                  emit;
   logic                  stall;

   assign slot_wide = SW'(req_ff.slot);
   assign slot_idx  = slot_wide[IW-1:0];
   assign in_bank   = slot_wide < SW'(NUM_TIMERS);
   assign slot_zero = req_ff.slot == '0;
   assign tmo       = COUNT_BITS'(req_ff.timeout);

   assign e_cyc    = rd_data_ff[EW-1];
   assign e_hnd    = rd_data_ff[EW-2];
   assign e_reload = rd_data_ff[2*COUNT_BITS-1:COUNT_BITS];
   assign e_count  = rd_data_ff[COUNT_BITS-1:0];

   assign act     = active_ff[p_idx_ff];
   assign is_exec = req_ff.func == FUNC_EXECUTE;
   assign fire    = p_ff && is_exec && act && (e_count == '0);
   assign emit    = fire && e_hnd && (n_ff < NW'(MAX_RESULTS));
   assign stall   = emit && hold_valid_ff && !can_push;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      active_in     = active_ff;
      delay_in      = delay_ff;
      rd_idx_in     = rd_idx_ff;
      p_in          = p_ff;
      p_idx_in      = p_idx_ff;
      hold_valid_in = hold_valid_ff;
      hold_slot_in  = hold_slot_ff;
      n_in          = n_ff;
      fin_in        = fin_ff;
      mem_ctl       = '0;
      wr_addr       = p_idx_ff;
      wr_data       = rd_data_ff;
      rd_addr       = rd_idx_ff[IW-1:0];
      push          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            fin_in.kind       = KIND_ACK;
            fin_in.fired_slot = '0;
            fin_in.expired    = 1'b0;
            fin_in.last       = 1'b1;
            state_in          = ST_FINAL;
            unique case (req_ff.func)
               FUNC_TICK: begin
                  if (delay_ff != '0) begin
                     delay_in = delay_ff - COUNT_BITS'(1);
                  end
                  rd_idx_in = CW'(1);
                  p_in      = 1'b0;
                  state_in  = ST_WALK;
               end
               FUNC_ADD: begin
                  if (in_bank && !slot_zero) begin
                     mem_ctl.wr_en       = 1'b1;
                     wr_addr             = slot_idx;
                     wr_data             = {req_ff.timer_type, req_ff.has_handler, tmo, tmo};
                     active_in[slot_idx] = 1'b1;
                  end
               end
               FUNC_REMOVE: begin
                  if (in_bank && !slot_zero) begin
                     active_in[slot_idx] = 1'b0;
                  end
               end
               FUNC_EXECUTE: begin
                  rd_idx_in     = CW'(1);
                  p_in          = 1'b0;
                  hold_valid_in = 1'b0;
                  n_in          = '0;
                  state_in      = ST_WALK;
               end
               FUNC_CHECK: begin
                  fin_in.kind       = KIND_CHECK;
                  fin_in.fired_slot = req_ff.slot;
                  fin_in.expired    = 1'b1;
                  if (slot_zero) begin
                     fin_in.expired = delay_ff == '0;
                  end else if (in_bank && active_ff[slot_idx]) begin
                     mem_ctl.rd_en = 1'b1;
                     rd_addr       = slot_idx;
                     state_in      = ST_CHECK;
                  end
               end
               FUNC_SET_DELAY: begin
                  delay_in = tmo;
               end
               default: begin
               end
            endcase
         end
         ST_CHECK: begin
            fin_in.expired = e_count == '0;
            state_in       = ST_FINAL;
         end
         ST_WALK: begin
            if (!stall) begin
               if (p_ff) begin
                  if (is_exec) begin
                     if (fire) begin
                        if (e_cyc) begin
                           mem_ctl.wr_en = 1'b1;
                           wr_data       = {e_cyc, e_hnd, e_reload, e_reload};
                        end else begin
                           active_in[p_idx_ff] = 1'b0;
                        end
                     end
                     if (emit) begin
                        if (hold_valid_ff) begin
                           push.en              = 1'b1;
                           push.data.kind       = KIND_FIRED;
                           push.data.fired_slot = hold_slot_ff;
                           push.data.expired    = 1'b0;
                           push.data.last       = 1'b0;
                        end
                        hold_valid_in = 1'b1;
                        hold_slot_in  = SLOT_W'(p_idx_ff);
                        n_in          = n_ff + NW'(1);
                     end
                  end else if (act && e_count != '0) begin
                     mem_ctl.wr_en = 1'b1;
                     wr_data       = {e_cyc, e_hnd, e_reload, e_count - COUNT_BITS'(1)};
                  end
               end
               if (rd_idx_ff < CW'(NUM_TIMERS)) begin
                  mem_ctl.rd_en = 1'b1;
                  p_in          = 1'b1;
                  p_idx_in      = rd_idx_ff[IW-1:0];
                  rd_idx_in     = rd_idx_ff + CW'(1);
               end else begin
                  p_in = 1'b0;
                  if (!p_ff) begin
                     state_in          = ST_FINAL;
                     fin_in.fired_slot = '0;
                     fin_in.expired    = 1'b0;
                     fin_in.last       = 1'b1;
                     fin_in.kind       = KIND_ACK;
                     if (is_exec && hold_valid_ff) begin
                        fin_in.kind       = KIND_FIRED;
                        fin_in.fired_slot = hold_slot_ff;
                     end else if (is_exec) begin
                        fin_in.kind = KIND_NONE;
                     end
                  end
               end
            end
         end
         ST_FINAL: begin
            if (can_push) begin
               push.en   = 1'b1;
               push.data = fin_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         timer_mem_ff[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= timer_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= NUM_TIMERS'(1);
         delay_ff      <= '0;
         p_ff          <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         delay_ff      <= delay_in;
         p_ff          <= p_in;
         hold_valid_ff <= hold_valid_in;
      end
      req_ff       <= req_in;
      rd_idx_ff    <= rd_idx_in;
      p_idx_ff     <= p_idx_in;
      hold_slot_ff <= hold_slot_in;
      n_ff         <= n_in;
      fin_ff       <= fin_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/software_timer_bank_top.sv =====
// Software timer bank: NUM_TIMERS down-counting slots, slot 0 a permanent delay timer.
// Top level; instantiates stb_ctrl and stb_rsp_stage. Depends on stb_pkg.
//
// One request is in work at a time. Add, remove, set delay and unused codes pass
// through the dispatch and final states to the result register, check also through
// the check state. Tick and execute walk slots 1 to NUM_TIMERS-1 through the slot
// memory (one read and one write port), one slot per cycle (read, then modify and
// write back while the next slot is read); execute also waits on the response
// channel whenever a fired event is ready and the previous one has not been taken.
// A new request is accepted while a result still sits in the response register.
// No clearing pass is needed after reset.
`default_nettype none

module software_timer_bank_top import stb_pkg::*; #(
   parameter int NUM_TIMERS = 16,
   parameter int COUNT_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   push_type push;
   logic     can_push;

   stb_ctrl #(
      .NUM_TIMERS (NUM_TIMERS),
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .can_push  (can_push),
      .push      (push)
   );

   stb_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .can_push  (can_push),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   a_partial_is_fired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.kind == KIND_FIRED)
      else $error("non-final transaction is not a fired event");

   a_expired_only_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_CHECK |-> !rsp_data.expired)
      else $error("expired set outside check status");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response produced while idle");

endmodule

`default_nettype wire
